[hdl/deadline_timer_queue_defines.svh]
// assertion macros for the deadline timer queue
// no dependencies
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("dtq check");
`define DTQ_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("dtq never");
`else
`define DTQ_ASSERT(label, clk, rst_n, prop)
`define DTQ_NEVER(label, clk, rst_n, cond)
`endif
`endif

[hdl/dtq_pkg.sv]
// types and codes for the deadline timer queue
// no dependencies
package dtq_pkg;
  typedef enum logic [1:0] {
    OP_SCHED_AT = 2'd0, OP_SCHED_AFTER = 2'd1, OP_CANCEL = 2'd2, OP_EXPIRE = 2'd3
  } op_e;
  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0, ST_CANCELLED = 3'd1, ST_NOT_FOUND = 3'd2, ST_EXPIRED = 3'd3,
    ST_NONE_DUE = 3'd4, ST_FULL = 3'd5, ST_EXHAUSTED = 3'd6
  } status_e;
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] time_arg;
    logic [63:0] current_time;
    logic [31:0] timer_ref;
  } cmd_t;
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] timer_id;
    logic [63:0] next_deadline;
    logic        next_valid;
    logic [4:0]  pending_count;
    logic        last;
  } rsp_t;
endpackage

[hdl/deadline_timer_queue.sv]
// deadline timer queue top level: ordered timer store with cancel and expire
// depends on dtq_pkg, dtq_ram and deadline_timer_queue_defines.svh
//
//  channel | direction | handshake            | payload
//  cmd     | in        | start, busy          | cmd_i (cmd_t)
//  rsp     | out       | rsp_valid_o (strobe) | rsp_o (rsp_t)
//
// each scan reads one slot per cycle from the slot ram
// every command runs scan, act, rescan, emit: the first result strobe is registered
// from the emit state, with busy already low if that beat is the last
// an expire chain sends each further beat after another pass
// (act, scan, act, scan, emit); busy stays high until the last beat's emit
// reset clears valid bits and control and sets the identifier counter to 1 at once; no sweep
// results are strobed for one cycle and cannot be stalled
`include "deadline_timer_queue_defines.svh"
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);
  localparam int AW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_ACT = 4'b0100, S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cmd_t cmd_q;
  logic [TIMER_SLOTS-1:0] valid_q;
  logic [31:0] next_id_q;
  // scan pointer, one wider so it can reach TIMER_SLOTS
  logic [AW:0] scan_q;
  logic        rd_pend_q;
  logic [AW-1:0] rd_idx_q;
  // scan results
  logic        best_ok_q;
  logic [63:0] best_dl_q;
  logic [31:0] best_id_q;
  logic [AW-1:0] best_idx_q;
  logic        hit_ok_q;
  logic [AW-1:0] hit_idx_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] n_out_q;
  // pending result awaiting refreshed earliest deadline
  logic [2:0]  pst_q;
  logic [31:0] pid_q;
  logic        plast_q;
  logic        emit_ok_q;

  logic        we;
  logic [AW-1:0] addr, free_idx;
  logic        free_ok;
  logic [95:0] wdata, rdata;
  logic [63:0] sum, deadline;
  logic        rd_valid, better;
  // earliest remaining timer is due and the per-command limit is not reached
  logic        expire_due;
  logic        emit_last;

  dtq_ram #(.Width(96), .Depth(TIMER_SLOTS)) u_slots (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_ok = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign sum = cmd_q.current_time + cmd_q.time_arg;
  assign deadline = (cmd_q.operation == OP_SCHED_AFTER) ?
                    ((sum < cmd_q.current_time) ? '1 : sum) : cmd_q.time_arg;
  assign rd_valid = rd_pend_q && valid_q[rd_idx_q];
  assign better = !best_ok_q || (rdata[95:32] < best_dl_q) ||
                  ((rdata[95:32] == best_dl_q) && (rdata[31:0] < best_id_q));
  assign busy = (state_q != S_IDLE);
  assign expire_due = best_ok_q && (best_dl_q <= cmd_q.current_time) &&
                      (n_out_q != CW'(TIMER_SLOTS));
  // an expire beat is the last once the refreshed view shows nothing more due
  assign emit_last = plast_q || !expire_due;

  // write only in act state for a schedule
  always_comb begin
    we = 1'b0;
    addr = scan_q[AW-1:0];
    wdata = {deadline, next_id_q};
    if (state_q == S_ACT && (cmd_q.operation == OP_SCHED_AT ||
        cmd_q.operation == OP_SCHED_AFTER) && next_id_q != '0 && free_ok) begin
      we = 1'b1;
      addr = free_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_SCAN;
      S_SCAN:  if (scan_q == TIMER_SLOTS[AW:0] && !rd_pend_q)
                 state_d = emit_ok_q ? S_EMIT : S_ACT;
      S_ACT:   state_d = S_SCAN;
      S_EMIT:  state_d = emit_last ? S_IDLE : S_ACT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      next_id_q <= 32'd1;
      scan_q <= '0;
      rd_pend_q <= 1'b0;
      emit_ok_q <= 1'b0;
      n_out_q <= '0;
      rsp_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rsp_valid_o <= (state_q == S_EMIT);
      unique case (state_q)
        S_IDLE: if (start) begin
          scan_q <= '0;
          rd_pend_q <= 1'b0;
          emit_ok_q <= 1'b0;
          n_out_q <= '0;
        end
        S_SCAN: begin
          rd_pend_q <= (scan_q != TIMER_SLOTS[AW:0]);
          if (scan_q != TIMER_SLOTS[AW:0]) scan_q <= scan_q + (AW+1)'(1);
        end
        S_ACT: begin
          // after a result beat the act only restarts the scan
          emit_ok_q <= !emit_ok_q;
          scan_q <= '0;
          rd_pend_q <= 1'b0;
          if (!emit_ok_q) begin
            unique case (cmd_q.operation) inside
              OP_SCHED_AT, OP_SCHED_AFTER: if (next_id_q != '0 && free_ok) begin
                valid_q[free_idx] <= 1'b1;
                next_id_q <= next_id_q + 32'd1;
              end
              OP_CANCEL: if (hit_ok_q) valid_q[hit_idx_q] <= 1'b0;
              OP_EXPIRE: if (expire_due) begin
                valid_q[best_idx_q] <= 1'b0;
                n_out_q <= n_out_q + CW'(1);
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          emit_ok_q <= !emit_last;
          scan_q <= '0;
          rd_pend_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload and scan accumulators
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) cmd_q <= cmd_i;
    if ((state_q == S_IDLE && start) || state_q == S_ACT || state_q == S_EMIT) begin
      best_ok_q <= 1'b0;
      hit_ok_q <= 1'b0;
      count_q <= '0;
    end else if (state_q == S_SCAN && rd_valid) begin
      count_q <= count_q + CW'(1);
      if (better) begin
        best_ok_q <= 1'b1;
        best_dl_q <= rdata[95:32];
        best_id_q <= rdata[31:0];
        best_idx_q <= rd_idx_q;
      end
      if (!hit_ok_q && rdata[31:0] == cmd_q.timer_ref) begin
        hit_ok_q <= 1'b1;
        hit_idx_q <= rd_idx_q;
      end
    end
    if (state_q == S_SCAN) rd_idx_q <= scan_q[AW-1:0];
    if (state_q == S_ACT && !emit_ok_q) begin
      unique case (cmd_q.operation) inside
        OP_SCHED_AT, OP_SCHED_AFTER: begin
          plast_q <= 1'b1;
          if (next_id_q == '0) begin
            pst_q <= ST_EXHAUSTED;
            pid_q <= '0;
          end else if (!free_ok) begin
            pst_q <= ST_FULL;
            pid_q <= '0;
          end else begin
            pst_q <= ST_SCHEDULED;
            pid_q <= next_id_q;
          end
        end
        OP_CANCEL: begin
          plast_q <= 1'b1;
          if (hit_ok_q) begin
            pst_q <= ST_CANCELLED;
            pid_q <= cmd_q.timer_ref;
          end else begin
            pst_q <= ST_NOT_FOUND;
            pid_q <= '0;
          end
        end
        OP_EXPIRE: begin
          if (expire_due) begin
            pst_q <= ST_EXPIRED;
            pid_q <= best_id_q;
            plast_q <= 1'b0;
          end else begin
            pst_q <= ST_NONE_DUE;
            pid_q <= '0;
            plast_q <= 1'b1;
          end
        end
        default: begin
          pst_q <= ST_NONE_DUE;
          pid_q <= '0;
          plast_q <= 1'b1;
        end
      endcase
    end
  end

  // a beat is sent after the scan behind it refreshes the view
  rsp_t        beat;
  always_comb begin
    beat.status = pst_q;
    beat.timer_id = pid_q;
    beat.next_deadline = best_ok_q ? best_dl_q : '0;
    beat.next_valid = best_ok_q;
    beat.pending_count = 5'(count_q);
    beat.last = emit_last;
  end
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT) rsp_o <= beat;
  end

  `DTQ_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `DTQ_NEVER(a_we_act, clk_i, rst_ni, we && state_q != S_ACT)
  `DTQ_NEVER(a_beat_state, clk_i, rst_ni, rsp_valid_o && state_q != S_IDLE && state_q != S_ACT)
  `DTQ_NEVER(a_empty, clk_i, rst_ni, rsp_valid_o && !rsp_o.next_valid && |rsp_o.next_deadline)
endmodule

[hdl/dtq_ram.sv]
// generic single-port ram with registered read
// no dependencies
module dtq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
